/* rtl/core/position_keyed_byte_decipher_macros.svh */
// Assertion macros used by the decipher top level.
`ifndef POSITION_KEYED_BYTE_DECIPHER_MACROS_SVH
`define POSITION_KEYED_BYTE_DECIPHER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PKBD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PKBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pkbd_pkg.sv */
// Shared types and constants of the position keyed byte decipher.
package pkbd_pkg;

    // Field and register widths.
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KEYLEN_W  = 6;
    localparam int unsigned EFFLEN_W  = 7;
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned POS_W     = 64;
    localparam int unsigned KEY_REGS  = 4;
    localparam int unsigned KEY_BYTES = KEY_REGS * (CFG_W / BYTE_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_3   = 3'd4;

    // One byte travelling down the row of cells.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              found;
        logic              pos_zero;
    } item_t;

endpackage

/* rtl/core/pkbd_cell.sv */
// One cell of the decipher row: a residue counter for one divisor and a stage register.
module pkbd_cell #(
    parameter int unsigned DIV = 1,
    parameter int unsigned RW  = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  logic                         active,
    input  logic [pkbd_pkg::BYTE_W-1:0]  key_byte,
    input  pkbd_pkg::item_t              prev,
    output pkbd_pkg::item_t              item
);

    localparam logic [RW-1:0] RES_LAST  = RW'(DIV - 1);
    localparam logic [RW-1:0] RES_RESET = (DIV == 1) ? '0 : RW'(1);

    logic [RW-1:0]   res_reg;
    logic [RW-1:0]   res_next;
    logic [RW-1:0]   res_now;
    logic            hit;
    pkbd_pkg::item_t item_reg;
    pkbd_pkg::item_t item_next;

    // The residue seen by the passing word; a wrapped position of zero restarts the count.
    assign res_now = prev.pos_zero ? '0 : res_reg;
    assign hit     = active && !prev.found && (res_now == '0);

    // Residue for the following word.
    always_comb
    begin
        res_next = res_reg;
        if (prev.valid)
        begin
            res_next = (res_now == RES_LAST) ? '0 : res_now + RW'(1);
        end
    end

    // The first matching cell subtracts its key byte and marks the word done.
    always_comb
    begin
        item_next = prev;
        if (hit)
        begin
            item_next.data  = prev.data - key_byte;
            item_next.found = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg  <= RES_RESET;
            item_reg <= '0;
        end
        else if (advance)
        begin
            res_reg  <= res_next;
            item_reg <= item_next;
        end
    end

    assign item = item_reg;

endmodule

/* rtl/core/position_keyed_byte_decipher.sv */
// An accepted word passes through every cell register of the row before its result reaches the output.
// Throughput: one word per cycle; the row of cells advances whenever the output is free.
// Each cell holds one key index and its position residue; the row length sets the latency.
// A stalled output holds the whole row, so input waits while a result is not taken.
// Reset: asynchronous, active low; position returns to 1, key length and key bytes to 0.
// Top level of the position keyed byte decipher.
module position_keyed_byte_decipher #(
    parameter int unsigned MAX_KEY = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pkbd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] cipher_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pkbd_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] plain_byte
    input  logic                            cfg_we,
    input  logic [pkbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [pkbd_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int unsigned NCELL = MAX_KEY - 1;
    localparam int unsigned RW    = $clog2(MAX_KEY);
    localparam logic [pkbd_pkg::EFFLEN_W-1:0] MAX_LEN = pkbd_pkg::EFFLEN_W'(MAX_KEY);

    logic [pkbd_pkg::KEYLEN_W-1:0] key_len_reg;
    logic [pkbd_pkg::CFG_W-1:0]    key_reg [pkbd_pkg::KEY_REGS];
    logic [pkbd_pkg::POS_W-1:0]    pos_reg;
    logic [pkbd_pkg::POS_W-1:0]    pos_inc;
    logic [pkbd_pkg::EFFLEN_W-1:0] len_ext;
    logic [pkbd_pkg::EFFLEN_W-1:0] eff_len;
    logic                          key_on;
    logic                          advance;
    logic                          accept;
    pkbd_pkg::item_t               head;
    pkbd_pkg::item_t               chain [NCELL+1];

    // Configuration writes; indexes beyond the key registers are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= '0;
            for (int k = 0; k < pkbd_pkg::KEY_REGS; k++)
            begin
                key_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                pkbd_pkg::REG_KEY_LEN: key_len_reg <= cfg_wdata[pkbd_pkg::KEYLEN_W-1:0];
                pkbd_pkg::REG_KEY_0:   key_reg[0]  <= cfg_wdata;
                pkbd_pkg::REG_KEY_1:   key_reg[1]  <= cfg_wdata;
                pkbd_pkg::REG_KEY_2:   key_reg[2]  <= cfg_wdata;
                pkbd_pkg::REG_KEY_3:   key_reg[3]  <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // Key length saturated to the number of cells plus one.
    assign len_ext = {1'b0, key_len_reg};
    assign eff_len = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;
    assign key_on  = (eff_len >= pkbd_pkg::EFFLEN_W'(2));

    // The whole row moves together unless a result waits at the output.
    assign advance  = !chain[NCELL].valid || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // Byte position; it wraps to zero after the all-ones value.
    assign pos_inc = pos_reg + pkbd_pkg::POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= pkbd_pkg::POS_W'(1);
        end
        else if (accept)
        begin
            pos_reg <= pos_inc;
        end
    end

    // Word entering the row.
    always_comb
    begin
        head.valid    = s_tvalid;
        head.data     = s_tdata;
        head.found    = 1'b0;
        head.pos_zero = (pos_reg == '0);
    end

    assign chain[0] = head;

    // Cells from the largest key index down to index 0.
    for (genvar c = 0; c < NCELL; c++)
    begin : g_cell
        localparam int unsigned IDX = NCELL - 1 - c;
        logic [pkbd_pkg::BYTE_W-1:0] kb;
        logic                        act;

        if (IDX < pkbd_pkg::KEY_BYTES)
        begin : g_key
            assign kb = key_reg[IDX / 8][(IDX % 8) * 8 +: 8];
        end
        else
        begin : g_nokey
            assign kb = '0;
        end

        assign act = (eff_len >= pkbd_pkg::EFFLEN_W'(IDX + 2));

        pkbd_cell #(
            .DIV (IDX + 1),
            .RW  (RW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .active   (act),
            .key_byte (kb),
            .prev     (chain[c]),
            .item     (chain[c+1])
        );
    end

    assign m_tvalid = chain[NCELL].valid;
    assign m_tdata  = chain[NCELL].data;

`include "position_keyed_byte_decipher_macros.svh"

    `PKBD_ASSERT_NEXT(a_pos_step, accept, pos_reg == $past(pos_inc), "position did not step")
    `PKBD_ASSERT_NEXT(a_pos_hold, !accept, $stable(pos_reg), "position moved while idle")
    `PKBD_ASSERT_SAME(a_idx0_hit, m_tvalid && key_on, chain[NCELL].found, "index 0 missed")
    `PKBD_ASSERT_SAME(a_no_key_hit, m_tvalid && !key_on, !chain[NCELL].found, "short key hit")

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking stream testbench of the position keyed byte decipher.
module testbench;

    localparam int unsigned BYTE_W        = pkbd_pkg::BYTE_W;
    localparam int unsigned CFG_W         = pkbd_pkg::CFG_W;
    localparam int unsigned CFG_IDX_W     = pkbd_pkg::CFG_IDX_W;
    localparam int unsigned KEYLEN_W      = pkbd_pkg::KEYLEN_W;
    localparam int unsigned KEY_REGS      = pkbd_pkg::KEY_REGS;
    localparam int unsigned KEY_BYTES     = pkbd_pkg::KEY_BYTES;
    localparam int unsigned POS_W         = pkbd_pkg::POS_W;
    localparam int unsigned MAX_KEY       = 32;
    localparam int unsigned PIPE_LAT      = MAX_KEY - 1;
    localparam int unsigned IDLE_PCT      = 23;
    localparam int unsigned RANDOM_TARGET = 700;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned KEYLEN_MAX    = (1 << KEYLEN_W) - 1;
    localparam int unsigned BYTES_PER_REG = CFG_W / BYTE_W;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    // Predictor copy of the key registers and the byte position.
    logic [KEYLEN_W-1:0]  key_len_q;
    logic [CFG_W-1:0]     key_words_q [KEY_REGS];
    logic [POS_W-1:0]     byte_pos_q;

    // Plaintext bytes still owed by the block, oldest first.
    logic [BYTE_W-1:0]    plain_queue [$];

    int unsigned error_count        = 0;
    int unsigned words_sent         = 0;
    int unsigned words_checked      = 0;
    int unsigned reg_writes         = 0;
    int unsigned cycle_count        = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned hold_request       = 0;
    bit          no_idle            = 1'b0;

    position_keyed_byte_decipher #(
        .MAX_KEY (MAX_KEY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter with a run limit; also counts cycles in which input is held back.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
            if (s_tvalid && !s_tready)
                input_stall_cycles++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Key byte lookup; indexes past the key registers read as zero.
    function automatic logic [BYTE_W-1:0] key_byte(int unsigned idx);
        if (idx >= KEY_BYTES)
            return '0;
        return key_words_q[idx / BYTES_PER_REG]
                          [(idx % BYTES_PER_REG) * BYTE_W +: BYTE_W];
    endfunction

    // Plaintext for one cipher byte at the current position.
    function automatic logic [BYTE_W-1:0] predict_plain(logic [BYTE_W-1:0] cipher);
        int unsigned eff_len;
        int          idx;
        bit          hit;
        eff_len = (key_len_q > MAX_KEY) ? MAX_KEY : key_len_q;
        predict_plain = cipher;
        hit = 1'b0;
        if (eff_len >= 2)
        begin
            // The largest index whose divisor splits the position wins.
            for (idx = eff_len - 2; idx >= 0 && !hit; idx--)
            begin
                if (byte_pos_q % POS_W'(idx + 1) == '0)
                begin
                    predict_plain = cipher - key_byte(idx);
                    hit = 1'b1;
                end
            end
        end
    endfunction

    function automatic logic [CFG_W-1:0] random_key_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one cipher byte, with random gaps, and records its plaintext once accepted.
    task automatic send_cipher(input logic [BYTE_W-1:0] cipher);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cipher;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        plain_queue.push_back(predict_plain(cipher));
        byte_pos_q++;
        words_sent++;
    endtask

    // One register write; the enable stays high until end_writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == pkbd_pkg::REG_KEY_LEN)
            key_len_q = value[KEYLEN_W-1:0];
        else if (idx >= pkbd_pkg::REG_KEY_0 && idx <= pkbd_pkg::REG_KEY_3)
            key_words_q[idx - pkbd_pkg::REG_KEY_0] = value;
        reg_writes++;
    endtask

    task automatic end_writes;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_key(input logic [CFG_W-1:0] len_word,
                               input logic [CFG_W-1:0] w0, input logic [CFG_W-1:0] w1,
                               input logic [CFG_W-1:0] w2, input logic [CFG_W-1:0] w3);
        write_reg(pkbd_pkg::REG_KEY_LEN, len_word);
        write_reg(pkbd_pkg::REG_KEY_0, w0);
        write_reg(pkbd_pkg::REG_KEY_1, w1);
        write_reg(pkbd_pkg::REG_KEY_2, w2);
        write_reg(pkbd_pkg::REG_KEY_3, w3);
        end_writes();
    endtask

    // Writes random data to every index past the last register.
    task automatic write_spare_regs;
        int k;
        for (k = REG_SPARE_LO; k <= REG_SPARE_HI; k++)
            write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
        end_writes();
    endtask

    // Lets the row of cells drain completely before the key is touched.
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (plain_queue.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // A short key or none at all passes bytes through unchanged.
    task automatic test_passthrough;
        send_cipher(8'h00);
        send_cipher(8'hFF);
        send_cipher(8'h5A);
        wait_idle();
        program_key(CFG_W'(1), '1, '1, '1, '1);
        send_cipher(8'hA5);
        send_cipher(8'hFF);
        wait_idle();
    endtask

    // Shortest real key, full key, and lengths that saturate at the maximum.
    task automatic test_key_extremes;
        int k;
        program_key(CFG_W'(2), '1, '0, '0, '0);
        send_cipher(8'h00);
        send_cipher(8'hFF);
        wait_idle();
        program_key(CFG_W'(MAX_KEY), 64'h0807060504030201, 64'h100F0E0D0C0B0A09,
                    64'h1817161514131211, 64'h201F1E1D1C1B1A19);
        for (k = 0; k < 8; k++)
            send_cipher(BYTE_W'($urandom));
        wait_idle();
        // Bits above the length field must be dropped.
        program_key({58'h2AAAAAAAAAAAAAA, 6'd33}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        for (k = 0; k < 4; k++)
            send_cipher(BYTE_W'($urandom));
        wait_idle();
        program_key('1, '1, '1, '1, '1);
        send_cipher(8'h00);
        send_cipher(8'h80);
        send_cipher(8'hFF);
        wait_idle();
    endtask

    // Writes to unused indexes leave the key alone.
    task automatic test_spare_registers;
        program_key(CFG_W'(4), {$urandom, $urandom}, '0, '0, '0);
        write_spare_regs();
        send_cipher(8'h01);
        send_cipher(8'hFE);
        send_cipher(8'h7F);
        wait_idle();
    endtask

    // The output holds off for a long stretch while bytes keep coming.
    task automatic test_backpressure;
        int k;
        program_key(CFG_W'(MAX_KEY), random_key_word(), random_key_word(),
                    random_key_word(), random_key_word());
        no_idle = 1'b1;
        hold_request = HOLD_CYCLES;
        for (k = 0; k < 100; k++)
            send_cipher(BYTE_W'($urandom));
        no_idle = 1'b0;
        wait_idle();
    endtask

    // Random keys and lengths, each followed by a stream of random bytes.
    task automatic test_random_streams;
        int unsigned sent;
        int unsigned phase;
        int unsigned count;
        int unsigned len;
        int unsigned k;
        logic [CFG_W-1:0] len_word;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_TARGET)
        begin
            case ($urandom_range(7))
                0:       len = 0;
                1:       len = 1;
                2:       len = 2;
                3:       len = MAX_KEY;
                4:       len = KEYLEN_MAX;
                default: len = $urandom_range(KEYLEN_MAX);
            endcase
            len_word = {$urandom, $urandom};
            len_word[KEYLEN_W-1:0] = KEYLEN_W'(len);
            program_key(len_word, random_key_word(), random_key_word(),
                        random_key_word(), random_key_word());
            if ($urandom_range(3) == 0)
                write_spare_regs();
            // One phase runs with both sides flat out.
            no_idle = (phase == 4);
            count = $urandom_range(30, 90);
            for (k = 0; k < count; k++)
                send_cipher(BYTE_W'($urandom));
            no_idle = 1'b0;
            sent += count;
            phase++;
            wait_idle();
        end
    endtask

    // Output side: checks each accepted word and drives tready.
    initial
    begin
        int unsigned       hold_left;
        logic [BYTE_W-1:0] want;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (plain_queue.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %02h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = plain_queue.pop_front();
                    words_checked++;
                    if (m_tdata !== want)
                    begin
                        $display("%0t: plain_byte mismatch, expected %02h, actual %02h",
                                 $time, want, m_tdata);
                        error_count++;
                    end
                end
            end
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Test sequence.
    initial
    begin
        int k;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= pkbd_pkg::REG_KEY_LEN;
        cfg_wdata <= '0;
        key_len_q = '0;
        for (k = 0; k < KEY_REGS; k++)
            key_words_q[k] = '0;
        byte_pos_q = POS_W'(1);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_passthrough();
        test_key_extremes();
        test_spare_registers();
        test_backpressure();
        test_random_streams();
        wait_idle();

        $display("Run covered %0d bytes and %0d register writes: key lengths from none to %0d,",
                 words_sent, reg_writes, KEYLEN_MAX);
        $display("spare indexes, and %0d cycles of input held back by a stalled output.",
                 input_stall_cycles);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* position_keyed_byte_decipher.f */
+incdir+rtl/core
rtl/core/pkbd_pkg.sv
rtl/core/pkbd_cell.sv
rtl/core/position_keyed_byte_decipher.sv
verif/testbench.sv
